// ===== rtl/core/bmp24_to_rgb565_window_streamer_defines.svh =====
// Assertion helpers for the window streamer.
`ifndef BMP24_TO_RGB565_WINDOW_STREAMER_DEFINES_SVH
`define BMP24_TO_RGB565_WINDOW_STREAMER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define BMPW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define BMPW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/core/bmpw_pkg.sv =====
package bmpw_pkg;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_REJECT = 2'd3
  } word_kind_e;

  localparam logic [15:0] CMD_HWIN  = 16'h0044;
  localparam logic [15:0] CMD_VWIN  = 16'h0045;
  localparam logic [15:0] CMD_RAMAD = 16'h0021;
  localparam logic [15:0] CMD_WRAM  = 16'h0022;

  localparam int unsigned MaxImageHeight = 4095;
  localparam int unsigned BmpDepth       = 24;
  localparam int unsigned HeaderEnd      = 34;

  // header byte positions that complete a field
  localparam logic [31:0] POS_OFFSET   = 32'd13;
  localparam logic [31:0] POS_WIDTH    = 32'd21;
  localparam logic [31:0] POS_HEIGHT   = 32'd25;
  localparam logic [31:0] POS_PLANES   = 32'd27;
  localparam logic [31:0] POS_DEPTH    = 32'd29;
  localparam logic [31:0] POS_COMPRESS = 32'd33;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QIdxW  = 2;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       file_start;
  } in_t;

  typedef struct packed {
    logic [1:0]  word_kind;
    logic [15:0] bus_word;
    logic        last_of_run;
  } out_t;

  // work handed from the parser to the word emitter
  typedef struct packed {
    logic        reject;
    logic        burst;
    logic        pixel;
    logic        finish;
    logic [7:0]  row;
    logic [7:0]  xs;
    logic [7:0]  xe;
    logic [15:0] word;
  } job_t;

endpackage

// ===== rtl/core/bmpw_front.sv =====
module bmpw_front #(
  parameter int unsigned PANEL_WIDTH     = 130,
  parameter int unsigned PANEL_HEIGHT    = 130,
  parameter int unsigned MAX_IMAGE_WIDTH = 1280
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  bmpw_pkg::in_t in_i,
  output logic          job_valid_o,
  output bmpw_pkg::job_t job_o
);
  import bmpw_pkg::*;

  localparam int unsigned WW = $clog2(MAX_IMAGE_WIDTH + 1);
  localparam int unsigned SW = $clog2(3 * MAX_IMAGE_WIDTH + 4);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_SKIP, PH_PIXELS, PH_DONE, PH_REJECTED
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [31:0]  pos_q, pos_d, hs_q, hs_d, off_q, off_d;
  logic [WW-1:0] wid_q, wid_d;
  logic [11:0]  hgt_q, hgt_d;
  logic [SW-1:0] stride_q, stride_d, rbc_q, rbc_d, rbc_n;
  logic [7:0]   row_q, row_d;
  logic [1:0]   k_q, k_d;
  logic [15:0]  acc_q, acc_d;

  phase_e       ph;
  logic [31:0]  pos, hs, hs_n;
  logic [7:0]   b, sw, sh, xs, xe, ys;
  logic         bad, pix, emit_pix, fin;
  logic [SW+11:0] prod;
  logic [32:0]  start;
  logic [SW+1:0] stride_w;

  always_comb begin
    b     = in_i.file_byte;
    ph    = in_i.file_start ? PH_HEADER : phase_q;
    pos   = in_i.file_start ? 32'd0 : pos_q;
    hs    = in_i.file_start ? 32'd0 : hs_q;
    hs_n  = {b, hs[31:8]};
    sw    = (32'(wid_q) > 32'(PANEL_WIDTH)) ? 8'(PANEL_WIDTH) : 8'(wid_q);
    sh    = (hgt_q > 12'(PANEL_HEIGHT)) ? 8'(PANEL_HEIGHT) : 8'(hgt_q);
    xs    = (8'(PANEL_WIDTH) - sw) >> 1;
    xe    = xs + sw - 8'd1;
    ys    = (8'(PANEL_HEIGHT) - sh) >> 1;
    prod  = (hgt_q > 12'(PANEL_HEIGHT)) ? (hgt_q - 12'(PANEL_HEIGHT)) * stride_q : '0;
    start = {1'b0, off_q} + 33'(prod);
    stride_w = (SW + 2)'(hs_n[WW-1:0]) * (SW + 2)'(3) + (SW + 2)'(3);

    phase_d = ph;
    pos_d   = pos;
    hs_d    = hs;
    off_d   = in_i.file_start ? 32'd0 : off_q;
    wid_d   = wid_q;
    hgt_d   = hgt_q;
    stride_d = stride_q;
    rbc_d   = rbc_q;
    row_d   = row_q;
    k_d     = k_q;
    acc_d   = acc_q;
    bad     = 1'b0;
    pix     = 1'b0;
    emit_pix = 1'b0;
    fin     = 1'b0;
    rbc_n   = rbc_q + SW'(1);

    if (ph == PH_HEADER) begin
      hs_d = hs_n;
      priority if (pos == POS_OFFSET) begin
        off_d = hs_n;
      end else if (pos == POS_WIDTH) begin
        if (hs_n == 32'd0 || hs_n > 32'(MAX_IMAGE_WIDTH)) bad = 1'b1;
        else begin
          wid_d    = hs_n[WW-1:0];
          stride_d = SW'(stride_w & ~(SW + 2)'(3));
        end
      end else if (pos == POS_HEIGHT) begin
        if (hs_n == 32'd0 || hs_n > 32'(MaxImageHeight)) bad = 1'b1;
        else hgt_d = hs_n[11:0];
      end else if (pos == POS_PLANES) begin
        bad = (hs_n[31:16] != 16'd1);
      end else if (pos == POS_DEPTH) begin
        bad = (hs_n[31:16] != 16'(BmpDepth));
      end else if (pos == POS_COMPRESS) begin
        if (hs_n != 32'd0) bad = 1'b1;
        else if (start < 33'(HeaderEnd)) bad = 1'b1;
        else begin
          off_d   = start[32] ? 32'hFFFF_FFFF : start[31:0];
          row_d   = ((8'(PANEL_HEIGHT) - sh) >> 1) + sh - 8'd1;
          rbc_d   = '0;
          k_d     = 2'd0;
          acc_d   = 16'd0;
          phase_d = PH_SKIP;
        end
      end else begin
      end
      if (bad) phase_d = PH_REJECTED;
    end else if (ph == PH_SKIP || ph == PH_PIXELS) begin
      pix = (ph == PH_PIXELS) || (pos == off_q);
      if (pix) begin
        phase_d = PH_PIXELS;
        if (rbc_q < SW'(10'(sw) * 10'd3)) begin
          unique case (k_q)
            2'd0:    acc_d = {11'd0, b[7:3]};
            2'd1:    acc_d = acc_q | {5'd0, b[7:2], 5'd0};
            default: begin
              acc_d    = acc_q | {b[7:3], 11'd0};
              emit_pix = 1'b1;
            end
          endcase
          k_d = (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        end
        rbc_d = rbc_n;
        if (row_q <= ys && rbc_n == SW'(10'(sw) * 10'd3)) begin
          fin     = 1'b1;
          phase_d = PH_DONE;
        end else if (rbc_n >= stride_q) begin
          rbc_d = '0;
          row_d = row_q - 8'd1;
          k_d   = 2'd0;
        end
      end
    end
    if (ph == PH_HEADER || ph == PH_SKIP || ph == PH_PIXELS) begin
      if (pos != 32'hFFFF_FFFF) pos_d = pos + 32'd1;
    end

    job_valid_o   = bad || (pix && (rbc_q == '0 || emit_pix));
    job_o.reject  = bad;
    job_o.burst   = pix && (rbc_q == '0);
    job_o.pixel   = emit_pix;
    job_o.finish  = fin;
    job_o.row     = row_q;
    job_o.xs      = xs;
    job_o.xe      = xe;
    job_o.word    = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_q    <= '0;
      hs_q     <= '0;
      off_q    <= '0;
      wid_q    <= '0;
      hgt_q    <= '0;
      stride_q <= '0;
      rbc_q    <= '0;
      row_q    <= '0;
      k_q      <= '0;
      acc_q    <= '0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      hs_q     <= hs_d;
      off_q    <= off_d;
      wid_q    <= wid_d;
      hgt_q    <= hgt_d;
      stride_q <= stride_d;
      rbc_q    <= rbc_d;
      row_q    <= row_d;
      k_q      <= k_d;
      acc_q    <= acc_d;
    end
  end

endmodule

// ===== rtl/core/bmpw_fifo.sv =====
module bmpw_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bmpw_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bmpw_pkg::job_t data_o
);
  import bmpw_pkg::*;

  job_t             mem_q [QDepth];
  logic [QIdxW-1:0] wp_q, rp_q;
  logic [QIdxW:0]   cnt_q;

  assign full_o  = (cnt_q == (QIdxW + 1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + QIdxW'(1);
      if (pop_i)  rp_q <= rp_q + QIdxW'(1);
      cnt_q <= cnt_q + (QIdxW + 1)'(push_i) - (QIdxW + 1)'(pop_i);
    end
  end

endmodule

// ===== rtl/core/bmpw_back.sv =====
module bmpw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     col_off_i,
  input  logic [7:0]     row_off_i,
  input  logic           empty_i,
  input  bmpw_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bmpw_pkg::out_t out_o
);
  import bmpw_pkg::*;

  localparam logic [3:0] ST_HWIN  = 4'd0;
  localparam logic [3:0] ST_HDAT  = 4'd1;
  localparam logic [3:0] ST_VWIN  = 4'd2;
  localparam logic [3:0] ST_VDAT  = 4'd3;
  localparam logic [3:0] ST_RAMAD = 4'd4;
  localparam logic [3:0] ST_ADAT  = 4'd5;
  localparam logic [3:0] ST_WRAM  = 4'd6;
  localparam logic [3:0] ST_PIX   = 4'd7;
  localparam logic [3:0] ST_STAT  = 4'd8;

  logic       busy_q;
  logic [3:0] step_q, cur, nxt;
  logic       last, free;
  logic [8:0] cxs, cxe, rr;
  out_t       word, out_q;
  logic       valid_q;

  always_comb begin
    cur  = busy_q ? step_q : (job_i.burst ? ST_HWIN : (job_i.pixel ? ST_PIX : ST_STAT));
    last = 1'b0;
    nxt  = cur + 4'd1;
    if (cur == ST_WRAM) begin
      nxt  = job_i.pixel ? ST_PIX : ST_STAT;
      last = !job_i.pixel && !job_i.finish;
    end else if (cur == ST_PIX) begin
      last = !job_i.finish;
    end else if (cur == ST_STAT) begin
      last = 1'b1;
    end
    cxs = {1'b0, col_off_i} + {1'b0, job_i.xs};
    cxe = {1'b0, col_off_i} + {1'b0, job_i.xe};
    rr  = {1'b0, row_off_i} + {1'b0, job_i.row};
    word.last_of_run = last;
    word.word_kind   = KIND_DATA;
    unique case (cur)
      ST_HWIN:  begin word.word_kind = KIND_CMD; word.bus_word = CMD_HWIN;  end
      ST_HDAT:  word.bus_word = {cxe[7:0], 8'd0} | {7'd0, cxs};
      ST_VWIN:  begin word.word_kind = KIND_CMD; word.bus_word = CMD_VWIN;  end
      ST_VDAT:  word.bus_word = {rr[7:0], 8'd0} | {7'd0, rr};
      ST_RAMAD: begin word.word_kind = KIND_CMD; word.bus_word = CMD_RAMAD; end
      ST_ADAT:  word.bus_word = {rr[7:0], 8'd0} | {7'd0, cxs};
      ST_WRAM:  begin word.word_kind = KIND_CMD; word.bus_word = CMD_WRAM;  end
      ST_PIX:   word.bus_word = job_i.word;
      default:  begin
        word.word_kind = job_i.reject ? KIND_REJECT : KIND_DONE;
        word.bus_word  = 16'd0;
      end
    endcase
    free  = !valid_q || out_ready_i;
    pop_o = free && !empty_i && last;
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      busy_q  <= 1'b0;
      step_q  <= ST_HWIN;
    end else if (free) begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        busy_q <= !last;
        step_q <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free && !empty_i) out_q <= word;
  end

endmodule

// ===== rtl/core/bmp24_to_rgb565_window_streamer.sv =====
// Streams a 24-bit BMP file in, one byte per transaction from file offset 0
// (file_start set on that byte), and emits panel command and RGB565 data
// words. Each accepted byte produces zero or more words, the final one of a
// byte flagged by last_of_run; a file rejection or image end gives a status
// word. Input: one byte per cycle while the 4-entry job queue has room.
// Output: one word per cycle while out_ready_i is high; a row start's
// seven-word window burst is one queue entry, popped with its last word, and
// a pixel one word per three bytes. Registers take effect on the next cycle.
module bmp24_to_rgb565_window_streamer #(
  parameter int unsigned PANEL_WIDTH     = 130,
  parameter int unsigned PANEL_HEIGHT    = 130,
  parameter int unsigned MAX_IMAGE_WIDTH = 1280
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bmpw_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bmpw_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [7:0]     cfg_data_i
);
  import bmpw_pkg::*;
  `include "bmp24_to_rgb565_window_streamer_defines.svh"

  localparam logic REG_COL_OFF = 1'b0;
  localparam logic REG_ROW_OFF = 1'b1;

  logic [7:0] col_off_q, row_off_q;
  logic       take, job_valid, full, empty, pop;
  job_t       job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_off_q <= '0;
      row_off_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_COL_OFF) col_off_q <= cfg_data_i;
      if (cfg_idx_i == REG_ROW_OFF) row_off_q <= cfg_data_i;
    end
  end

  // a byte is taken only when its job, if any, has a queue slot
  assign in_ready_o = !full;
  assign take       = in_valid_i && in_ready_o;

  bmpw_front #(
    .PANEL_WIDTH    (PANEL_WIDTH),
    .PANEL_HEIGHT   (PANEL_HEIGHT),
    .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .in_i       (in_data_i),
    .job_valid_o(job_valid),
    .job_o      (job_in)
  );

  bmpw_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (take && job_valid),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (job_out)
  );

  bmpw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .col_off_i  (col_off_q),
    .row_off_i  (row_off_q),
    .empty_i    (empty),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_data_o)
  );

  `BMPW_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop && empty, "queue popped while empty")
  `BMPW_ASSERT_IMPL(a_status_last, clk_i, rst_ni,
                    out_valid_o && (out_data_o.word_kind == KIND_DONE ||
                    out_data_o.word_kind == KIND_REJECT),
                    out_data_o.last_of_run && out_data_o.bus_word == 16'd0,
                    "status word not final or not zero")
  `BMPW_ASSERT_IMPL(a_full_stall, clk_i, rst_ni, full, !in_ready_o,
                    "byte taken with job queue full")

endmodule
